### src/trse_pkg.sv
// types, constants and rounding helper for the ribbon surface evaluator
// no dependencies
package trse_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_FRAC    = 30;
    localparam int TURN_BITS    = 32;
    localparam int TW           = 34;
    localparam int PW           = 70;

    localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in 2^-32 of a full turn
    localparam logic signed [TW-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic [15:0] angle_u;
        logic [15:0] angle_v;
    } t_in;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic signed [15:0] du_x;
        logic signed [15:0] du_y;
        logic signed [15:0] du_z;
        logic signed [15:0] dv_x;
        logic signed [15:0] dv_y;
        logic signed [15:0] dv_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_out;

    // round half up by s bits, then saturate to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [PW-1:0] p,
                                                   input int unsigned s);
        logic signed [PW-1:0] t;
        t = (p + (PW'(1) << (s - 1))) >>> s;
        if (t > PW'(32767))
            return 16'sh7fff;
        else if (t < -PW'(32768))
            return -16'sh8000;
        else
            return t[15:0];
    endfunction

endpackage

### src/twisted_ribbon_surface_eval_top.sv
// ribbon surface evaluator: pipelined cordic sin/cos of u and v, products,
// rounding and saturation; depends on trse_pkg
//
// usage:
//   input channel i_valid/o_ready/i_data carries one (angle_u, angle_v) beat,
//   output channel o_valid/i_ready/o_data carries point, both tangents and
//   the normal, all signed fixed point with FRAC_BITS fraction bits.
// pipeline: 30 register stages from the accepting edge to o_valid at the output
//   register (1 input stage, 24 cordic rotation stages, quadrant fold,
//   two partial-product stages, sign select, round and saturate).
// throughput: one beat per cycle unless the output stalls; set by one cordic
//   rotation per stage for u and v in parallel and by split 34x18 multipliers.
// reset: synchronous on i_rst_n low; clears all stage valid bits, so the
//   pipe comes up empty and o_valid is low.
// stall: when the output beat is held with i_ready low, the whole pipe
//   freezes and o_ready drops; nothing is lost or repeated. o_ready is high
//   whenever the output register is empty or being taken.
// ANGLE_BITS sets how many angle bits make a full turn, FRAC_BITS the
//   output fraction bits.
module twisted_ribbon_surface_eval_top
    import trse_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int NST = CORDIC_STEPS + 6;
    localparam int SH1 = TRIG_FRAC - FRAC_BITS;
    localparam int SH2 = 2 * TRIG_FRAC - FRAC_BITS;
    localparam int ZSH = TURN_BITS - ANGLE_BITS;

    logic en;
    logic r_vld [0:NST-1];

    assign en      = !r_vld[NST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // angle reduction: quadrant and remainder
    logic [ANGLE_BITS+15:0] ext [0:1];
    logic [ANGLE_BITS-1:0]  ang [0:1];
    assign ext[0] = {ANGLE_BITS'(0), i_data.angle_u};
    assign ext[1] = {ANGLE_BITS'(0), i_data.angle_v};
    assign ang[0] = ext[0][ANGLE_BITS-1:0];
    assign ang[1] = ext[1][ANGLE_BITS-1:0];

    logic signed [TW-1:0] r_x [0:1][0:CORDIC_STEPS];
    logic signed [TW-1:0] r_y [0:1][0:CORDIC_STEPS];
    logic signed [TW-1:0] r_z [0:1][0:CORDIC_STEPS];
    logic [1:0] r_quad [0:1][0:CORDIC_STEPS];
    logic r_sgz [0:CORDIC_STEPS];
    logic r_sgp [0:CORDIC_STEPS];

    logic rest_zero;
    assign rest_zero = (ang[0][ANGLE_BITS-3:0] == '0);

    for (genvar l = 0; l < 2; l++) begin : g_lane
        // input stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[l][0]    <= CORDIC_GAIN;
                r_y[l][0]    <= '0;
                r_z[l][0]    <= {4'b0000, ang[l][ANGLE_BITS-3:0], ZSH'(0)};
                r_quad[l][0] <= ang[l][ANGLE_BITS-1:ANGLE_BITS-2];
            end
        end

        // one rotation per stage, both angles side by side
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_z[l][k][TW-1]) begin
                        r_x[l][k+1] <= r_x[l][k] - (r_y[l][k] >>> k);
                        r_y[l][k+1] <= r_y[l][k] + (r_x[l][k] >>> k);
                        r_z[l][k+1] <= r_z[l][k] - ATAN_TURN[k];
                    end else begin
                        r_x[l][k+1] <= r_x[l][k] + (r_y[l][k] >>> k);
                        r_y[l][k+1] <= r_y[l][k] - (r_x[l][k] >>> k);
                        r_z[l][k+1] <= r_z[l][k] + ATAN_TURN[k];
                    end
                    r_quad[l][k+1] <= r_quad[l][k];
                end
            end
        end
    end

    // sign of cos u, exact from the angle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sgz[0] <= rest_zero && ang[0][ANGLE_BITS-2];
            r_sgp[0] <= (ang[0][ANGLE_BITS-1:ANGLE_BITS-2] == 2'd0) ||
                        ((ang[0][ANGLE_BITS-1:ANGLE_BITS-2] == 2'd3) && !rest_zero);
        end
    end

    // sign flags follow the rotation stages
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_sg
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sgz[k+1] <= r_sgz[k];
                r_sgp[k+1] <= r_sgp[k];
            end
        end
    end

    // quadrant fold
    logic signed [TW-1:0] su, cv, sv;
    always_comb begin
        case (r_quad[0][CORDIC_STEPS])
            2'd0:    su = r_y[0][CORDIC_STEPS];
            2'd1:    su = r_x[0][CORDIC_STEPS];
            2'd2:    su = -r_y[0][CORDIC_STEPS];
            default: su = -r_x[0][CORDIC_STEPS];
        endcase
        case (r_quad[1][CORDIC_STEPS])
            2'd0: begin
                cv = r_x[1][CORDIC_STEPS];
                sv = r_y[1][CORDIC_STEPS];
            end
            2'd1: begin
                cv = -r_y[1][CORDIC_STEPS];
                sv = r_x[1][CORDIC_STEPS];
            end
            2'd2: begin
                cv = -r_x[1][CORDIC_STEPS];
                sv = -r_y[1][CORDIC_STEPS];
            end
            default: begin
                cv = r_y[1][CORDIC_STEPS];
                sv = -r_x[1][CORDIC_STEPS];
            end
        endcase
    end

    logic signed [TW-1:0] r_qsu3, r_qcv, r_qsv;
    logic r_qsgz, r_qsgp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qsu3 <= (su <<< 1) + su;
            r_qcv  <= cv;
            r_qsv  <= sv;
            r_qsgz <= r_sgz[CORDIC_STEPS];
            r_qsgp <= r_sgp[CORDIC_STEPS];
        end
    end

    // partial products: su3*cv, su3*sv, sv*sv, cv*sv
    logic signed [TW-1:0] opa [0:3];
    logic signed [TW-1:0] opb [0:3];
    assign opa[0] = r_qsu3;
    assign opb[0] = r_qcv;
    assign opa[1] = r_qsu3;
    assign opb[1] = r_qsv;
    assign opa[2] = r_qsv;
    assign opb[2] = r_qsv;
    assign opa[3] = r_qcv;
    assign opb[3] = r_qsv;

    logic signed [TW+17:0] r_plo [0:3];
    logic signed [TW+16:0] r_phi [0:3];
    logic signed [TW-1:0]  r_1su3, r_1cv, r_1sv;
    logic r_1sgz, r_1sgp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_plo[j] <= opa[j] * $signed({1'b0, opb[j][16:0]});
                r_phi[j] <= opa[j] * $signed(opb[j][TW-1:17]);
            end
            r_1su3 <= r_qsu3;
            r_1cv  <= r_qcv;
            r_1sv  <= r_qsv;
            r_1sgz <= r_qsgz;
            r_1sgp <= r_qsgp;
        end
    end

    // partial product sum
    logic signed [PW-1:0] r_p [0:3];
    logic signed [TW-1:0] r_2su3, r_2cv, r_2sv;
    logic r_2sgz, r_2sgp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++)
                r_p[j] <= (PW'(r_phi[j]) <<< 17) + PW'(r_plo[j]);
            r_2su3 <= r_1su3;
            r_2cv  <= r_1cv;
            r_2sv  <= r_1sv;
            r_2sgz <= r_1sgz;
            r_2sgp <= r_1sgp;
        end
    end

    // sign select on full-width values
    function automatic logic signed [PW-1:0] sgmul(input logic signed [PW-1:0] a,
                                                   input logic z, input logic p);
        if (z)
            return '0;
        else if (p)
            return a;
        else
            return -a;
    endfunction

    logic signed [PW-1:0] r_v [0:10];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v[0]  <= r_p[0];
            r_v[1]  <= r_p[1];
            r_v[2]  <= PW'(r_2cv);
            r_v[3]  <= sgmul(PW'(r_2cv), r_2sgz, r_2sgp);
            r_v[4]  <= sgmul(PW'(r_2sv), r_2sgz, r_2sgp);
            r_v[5]  <= -r_p[1];
            r_v[6]  <= r_p[0];
            r_v[7]  <= -PW'(r_2sv);
            r_v[8]  <= sgmul(-r_p[2], r_2sgz, r_2sgp);
            r_v[9]  <= sgmul(r_p[3], r_2sgz, r_2sgp);
            r_v[10] <= sgmul(PW'(r_2su3), r_2sgz, r_2sgp);
        end
    end

    // round, saturate, output register
    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.point_x  <= rnd_sat(r_v[0], SH2);
            r_out.point_y  <= rnd_sat(r_v[1], SH2);
            r_out.point_z  <= rnd_sat(r_v[2], SH1);
            r_out.du_x     <= rnd_sat(r_v[3], SH1);
            r_out.du_y     <= rnd_sat(r_v[4], SH1);
            r_out.du_z     <= '0;
            r_out.dv_x     <= rnd_sat(r_v[5], SH2);
            r_out.dv_y     <= rnd_sat(r_v[6], SH2);
            r_out.dv_z     <= rnd_sat(r_v[7], SH1);
            r_out.normal_x <= rnd_sat(r_v[8], SH2);
            r_out.normal_y <= rnd_sat(r_v[9], SH2);
            r_out.normal_z <= rnd_sat(r_v[10], SH1);
        end
    end

    assign o_data = r_out;

endmodule

### src/trse_checker.sv
// port-level checks for the ribbon surface evaluator, bound to the top level
// depends on trse_pkg and twisted_ribbon_surface_eval_top
module trse_checker
    import trse_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // a held output beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped under stall");

    // a held output beat keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("output payload changed under stall");

    // input side only waits on a stalled full output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // u tangent has no z part
    a_duz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.du_z == 16'sd0)
        else $error("du_z not zero");

    // pipe comes up empty after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind twisted_ribbon_surface_eval_top trse_checker u_trse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
